>>> hdl/assert_macros.svh
// assertion helpers, clocked on clk_i and silent while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every enabled edge
`define ASSERT_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expression must never be true
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

>>> hdl/ssrg_pkg.sv
`default_nettype none

package ssrg_pkg;

  localparam int SegCount = 7;

  // segment slots within one digit, in emission order
  localparam logic [2:0] SegTop    = 3'd0;
  localparam logic [2:0] SegUpperA = 3'd1;
  localparam logic [2:0] SegUpperB = 3'd2;
  localparam logic [2:0] SegMiddle = 3'd3;
  localparam logic [2:0] SegLowerA = 3'd4;
  localparam logic [2:0] SegLowerB = 3'd5;
  localparam logic [2:0] SegBottom = 3'd6;

  // configuration register indexes
  localparam logic [2:0] RegScreenWidth  = 3'd0;
  localparam logic [2:0] RegOriginY      = 3'd1;
  localparam logic [2:0] RegOriginX      = 3'd2;
  localparam logic [2:0] RegSegmentWidth = 3'd3;
  localparam logic [2:0] RegLineWidthSet = 3'd4;
  localparam logic [2:0] RegHoldLine     = 3'd5;
  localparam logic [2:0] RegGapSet       = 3'd6;
  localparam logic [2:0] RegHoldGap      = 3'd7;

  // reciprocals: x*683 >> 12 is x/6 and >> 11 is x/3 for 10-bit x,
  // v*6554 >> 16 is v/10 for 14-bit v
  localparam logic [9:0]  RecipThird = 10'd683;
  localparam logic [12:0] RecipTenth = 13'd6554;

  typedef logic signed [15:0] coord_t;

  typedef struct packed {
    logic [9:0]  screen_width;
    logic [9:0]  origin_y;
    logic [9:0]  origin_x;
    logic [9:0]  segment_width;
    logic [7:0]  line_width_set;
    logic        hold_line_width;
    logic [10:0] gap_set;
    logic        hold_gap;
  } cfg_t;

  // per-item geometry handed from prep to the generator
  typedef struct packed {
    logic   erase_all;
    coord_t l;
    coord_t s;
    coord_t sw;
    coord_t swl;
    coord_t pitch;
    coord_t y1;
    coord_t dx1;
    coord_t dx2;
    coord_t dx3;
  } geom_t;

  // segments that are dark for each decimal digit, bit n for segment n
  function automatic logic [6:0] seg_off(input logic [3:0] digit);
    logic [6:0] off;
    unique case (digit)
      4'd0:    off = 7'h08;
      4'd1:    off = 7'h5B;
      4'd2:    off = 7'h22;
      4'd3:    off = 7'h12;
      4'd4:    off = 7'h51;
      4'd5:    off = 7'h14;
      4'd6:    off = 7'h05;
      4'd7:    off = 7'h5A;
      4'd8:    off = 7'h00;
      4'd9:    off = 7'h50;
      default: off = 7'h7F;
    endcase
    return off;
  endfunction

  // power of ten, elaboration only
  function automatic logic [26:0] pow10(input int unsigned e);
    logic [26:0] acc;
    acc = 27'd1;
    for (int unsigned i = 0; i < e; i++) begin
      acc = acc * 27'd10;
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

>>> hdl/ssrg_prep.sv
`default_nettype none

`include "assert_macros.svh"

module ssrg_prep #(
  parameter int NUM_DIGITS = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ssrg_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            func_i,
  input  logic [13:0]     value_i,
  input  logic            row_i,
  output logic            job_valid_o,
  input  logic            job_ready_i,
  output ssrg_pkg::geom_t job_o,
  output logic [3:0]      digits_o [NUM_DIGITS]
);
  import ssrg_pkg::*;

  localparam int PrepSteps = (NUM_DIGITS > 5) ? NUM_DIGITS : 5;
  localparam int CntW = $clog2(PrepSteps);
  localparam int Divisor = (NUM_DIGITS > 1) ? NUM_DIGITS - 1 : 1;
  localparam bit MultiDigit = (NUM_DIGITS > 1);
  localparam logic [16:0] RecipM = 17'(65536 / Divisor);
  localparam logic [26:0] Limit = pow10(NUM_DIGITS);

  localparam logic [CntW-1:0] StepLine = CntW'(0);
  localparam logic [CntW-1:0] StepSpan = CntW'(1);
  localparam logic [CntW-1:0] StepMul  = CntW'(2);
  localparam logic [CntW-1:0] StepGap  = CntW'(3);
  localparam logic [CntW-1:0] StepJob  = CntW'(4);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [13:0] v_q;
  logic        func_q;
  logic        row_q;
  logic [3:0]  digs_q [NUM_DIGITS];
  logic [7:0]  l_q;
  logic [10:0] s_q;
  logic        neg_q;
  logic [13:0] mag_q;
  logic [30:0] prod_q;
  logic [15:0] g_q;
  geom_t       job_q;

  logic accept, start, hand, work, too_big;

  assign hand        = done_q && job_ready_i;
  assign in_ready_o  = !busy_q || hand;
  assign accept      = in_valid_i && in_ready_o;
  assign too_big     = ({13'd0, value_i} >= Limit);
  assign start       = accept && !(!func_i && too_big);
  assign work        = busy_q && !done_q;
  assign job_valid_o = done_q;
  assign job_o       = job_q;
  assign digits_o    = digs_q;

  // digit peel, least significant first
  logic [26:0] prod10;
  logic [13:0] quot, rem;
  assign prod10 = v_q * RecipTenth;
  assign quot   = {3'd0, prod10[26:16]};
  assign rem    = v_q - (quot << 3) - (quot << 1);

  // line width and segment height
  logic [19:0] sw_p;
  logic [7:0]  l_pick, l_next;
  logic [10:0] s_next;
  assign sw_p   = cfg_i.segment_width * RecipThird;
  assign l_pick = cfg_i.hold_line_width ? cfg_i.line_width_set : sw_p[19:12];
  assign l_next = (l_pick == 8'd0) ? 8'd1 : l_pick;
  assign s_next = {1'b0, cfg_i.segment_width} + {2'd0, sw_p[19:11]};

  // free space left for the gaps
  logic [10:0] swl;
  logic [15:0] span, num, mag16;
  assign swl   = {1'b0, cfg_i.segment_width} + {3'd0, l_q};
  assign span  = 16'(NUM_DIGITS) * {5'd0, swl};
  assign num   = {6'd0, cfg_i.screen_width} - span - {5'd0, cfg_i.origin_y, 1'b0};
  assign mag16 = num[15] ? (16'd0 - num) : num;

  // quotient by reciprocal, one correction step, sign restored
  logic [30:0] prod_c;
  logic [13:0] q0, qfix;
  logic [16:0] qd, r17;
  logic [15:0] gdiv, g_next;
  assign prod_c = mag_q * RecipM;
  assign q0     = prod_q[29:16];
  assign qd     = {3'd0, q0} * 17'(Divisor);
  assign r17    = {3'd0, mag_q} - qd;
  assign qfix   = (r17 >= 17'(Divisor)) ? q0 + 14'd1 : q0;
  assign gdiv   = neg_q ? (16'd0 - {2'd0, qfix}) : {2'd0, qfix};
  assign g_next = cfg_i.hold_gap ? {{5{cfg_i.gap_set[10]}}, cfg_i.gap_set}
                                 : (MultiDigit ? gdiv : 16'd0);

  // row placement
  logic [15:0] ox16, s16, l16, sw16, dx1;
  assign ox16 = {6'd0, cfg_i.origin_x};
  assign s16  = {5'd0, s_q};
  assign l16  = {8'd0, l_q};
  assign sw16 = {6'd0, cfg_i.segment_width};
  assign dx1  = row_q ? (ox16 + ox16 + s16 + s16 + g_q + g_q) : ox16;

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    if (hand) begin
      busy_d = 1'b0;
      done_d = 1'b0;
    end
    if (work) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(PrepSteps - 1)) begin
        done_d = 1'b1;
      end
    end
    if (start) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      v_q    <= value_i;
      func_q <= func_i;
      row_q  <= row_i;
    end else if (work) begin
      if ({1'b0, cnt_q} < (CntW + 1)'(NUM_DIGITS)) begin
        v_q       <= quot;
        digs_q[0] <= rem[3:0];
        for (int i = 1; i < NUM_DIGITS; i++) begin
          digs_q[i] <= digs_q[i-1];
        end
      end
      unique case (cnt_q)
        StepLine: begin
          l_q <= l_next;
          s_q <= s_next;
        end
        StepSpan: begin
          neg_q <= num[15];
          mag_q <= mag16[13:0];
        end
        StepMul: prod_q <= prod_c;
        StepGap: g_q    <= g_next;
        StepJob: begin
          job_q.erase_all <= func_q;
          job_q.l         <= l16;
          job_q.s         <= s16;
          job_q.sw        <= sw16;
          job_q.swl       <= sw16 + l16;
          job_q.pitch     <= sw16 + l16 + g_q;
          job_q.y1        <= {6'd0, cfg_i.origin_y};
          job_q.dx1       <= dx1;
          job_q.dx2       <= dx1 + s16;
          job_q.dx3       <= dx1 + s16 + s16;
        end
        default: ;
      endcase
    end
  end

  `ASSERT_HOLDS(prep_done_needs_busy, done_q |-> busy_q, "prep done without an item")
  `ASSERT_NEVER(prep_start_while_working, start && work, "item taken during prep")

endmodule

`default_nettype wire

>>> hdl/ssrg_gen.sv
`default_nettype none

`include "assert_macros.svh"

module ssrg_gen #(
  parameter int NUM_DIGITS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  ssrg_pkg::geom_t   job_i,
  input  logic [3:0]        digits_i [NUM_DIGITS],
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ssrg_pkg::coord_t  rect_y_o,
  output ssrg_pkg::coord_t  rect_x_o,
  output ssrg_pkg::coord_t  rect_w_o,
  output ssrg_pkg::coord_t  rect_h_o,
  output logic              erase_o,
  output logic              last_o
);
  import ssrg_pkg::*;

  localparam int DigW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  logic            active_q;
  logic [2:0]      seg_q;
  logic [DigW-1:0] dig_q;
  logic            out_valid_q;
  coord_t          dy1_q;
  geom_t           geom_q;
  logic [3:0]      digs_q [NUM_DIGITS];
  coord_t          ry_q, rx_q, rw_q, rh_q;
  logic            erase_q, last_q;

  logic adv, final_step, load, del;
  logic [6:0] off;
  coord_t ry, rx, rw, rh, dy1_ml, dy2_ml, rx_side;

  assign adv         = active_q && (!out_valid_q || out_ready_i);
  assign final_step  = (seg_q == SegBottom) && (dig_q == DigW'(NUM_DIGITS - 1));
  assign job_ready_o = !active_q || (adv && final_step);
  assign load        = job_valid_i && job_ready_o;

  assign off     = seg_off(digs_q[dig_q]);
  assign del     = geom_q.erase_all | off[seg_q];
  assign dy1_ml  = dy1_q - geom_q.l;
  assign dy2_ml  = dy1_q + geom_q.sw;
  assign rx_side = del ? geom_q.dx1 + geom_q.l : geom_q.dx1;

  always_comb begin
    unique case (seg_q)
      SegTop: begin
        ry = dy1_ml;  rx = geom_q.dx1;  rw = geom_q.swl + geom_q.l;  rh = geom_q.l;
      end
      SegUpperA: begin
        ry = dy1_ml;  rx = rx_side;  rw = geom_q.l;  rh = geom_q.s;
      end
      SegUpperB: begin
        ry = dy2_ml;  rx = rx_side;  rw = geom_q.l;  rh = geom_q.s;
      end
      SegMiddle: begin
        ry = dy1_q;  rx = geom_q.dx2;  rw = geom_q.swl;  rh = geom_q.l;
      end
      SegLowerA: begin
        ry = dy1_ml;  rx = geom_q.dx2;  rw = geom_q.l;  rh = geom_q.s + geom_q.l;
      end
      SegLowerB: begin
        ry = dy2_ml;  rx = geom_q.dx2;  rw = geom_q.l;  rh = geom_q.s + geom_q.l;
      end
      default: begin
        ry = dy1_ml;  rx = geom_q.dx3;  rw = geom_q.swl;  rh = geom_q.l;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      seg_q       <= SegTop;
      dig_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load) begin
        active_q <= 1'b1;
        seg_q    <= SegTop;
        dig_q    <= '0;
      end else if (adv) begin
        if (seg_q == SegBottom) begin
          seg_q <= SegTop;
          dig_q <= dig_q + 1'b1;
          if (final_step) begin
            active_q <= 1'b0;
          end
        end else begin
          seg_q <= seg_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ry_q    <= ry;
      rx_q    <= rx;
      rw_q    <= rw;
      rh_q    <= rh;
      erase_q <= del;
      last_q  <= final_step;
    end
    if (load) begin
      geom_q <= job_i;
      digs_q <= digits_i;
      dy1_q  <= job_i.y1;
    end else if (adv && (seg_q == SegBottom)) begin
      dy1_q <= dy1_q + geom_q.pitch;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rect_y_o    = ry_q;
  assign rect_x_o    = rx_q;
  assign rect_w_o    = rw_q;
  assign rect_h_o    = rh_q;
  assign erase_o     = erase_q;
  assign last_o      = last_q;

  `ASSERT_HOLDS(gen_seg_range, active_q |-> (seg_q <= SegBottom), "segment slot past the bottom")
  `ASSERT_HOLDS(gen_load_restarts, load |=> (active_q && seg_q == SegTop && dig_q == '0), "load did not restart")
  `ASSERT_HOLDS(gen_run_ends, (adv && final_step && !load) |=> !active_q, "run kept going after last")

endmodule

`default_nettype wire

>>> hdl/seven_segment_rect_generator_unit.sv
`default_nettype none

// channel   | dir | handshake              | payload
// ----------+-----+------------------------+-----------------------------------------
// s_axis    | in  | s_axis_tvalid/tready   | tdata: value, row; tuser: func
// m_axis    | out | m_axis_tvalid/tready   | tdata: rect_y, rect_x, rect_w, rect_h;
//           |     |                        | tuser: erase; tlast: last of run
// cfg       | in  | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i (always ready)
//
// each erase item and each in-range draw item gives 7*NUM_DIGITS rectangles, one per cycle when m_axis
// is not stalled; the generator's single rectangle per cycle sets that rate
// the prep stage does the digit peel and the gap divide for each item and
// works on the next item while the current run is emitted
// first rectangle leaves the generator's output registers once prep has handed the item over
// a draw item with too large a value is taken and dropped, no rectangles
// reset clears all handshake state and loads the register defaults

`include "assert_macros.svh"

module seven_segment_rect_generator_unit #(
  parameter int NUM_DIGITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [13:0] value, [14] row, [15] zero
  input  logic        s_axis_tuser,   // [0] func
  // rectangle commands
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [15:0] rect_y, [31:16] rect_x,
                                      // [47:32] rect_w, [63:48] rect_h
  output logic        m_axis_tuser,   // [0] erase
  output logic        m_axis_tlast,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);
  import ssrg_pkg::*;

  cfg_t cfg_q;

  // register file, writes are to land only while the block is idle; the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width    <= 10'd128;
      cfg_q.origin_y        <= 10'd8;
      cfg_q.origin_x        <= 10'd8;
      cfg_q.segment_width   <= 10'd12;
      cfg_q.line_width_set  <= 8'd2;
      cfg_q.hold_line_width <= 1'b0;
      cfg_q.gap_set         <= 11'd0;
      cfg_q.hold_gap        <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegScreenWidth:  cfg_q.screen_width    <= cfg_data_i[9:0];
        RegOriginY:      cfg_q.origin_y        <= cfg_data_i[9:0];
        RegOriginX:      cfg_q.origin_x        <= cfg_data_i[9:0];
        RegSegmentWidth: cfg_q.segment_width   <= cfg_data_i[9:0];
        RegLineWidthSet: cfg_q.line_width_set  <= cfg_data_i[7:0];
        RegHoldLine:     cfg_q.hold_line_width <= cfg_data_i[0];
        RegGapSet:       cfg_q.gap_set         <= cfg_data_i;
        default:         cfg_q.hold_gap        <= cfg_data_i[0];
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // prep to generator hand-off
  logic       job_valid, job_ready;
  geom_t      job;
  logic [3:0] digits [NUM_DIGITS];

  ssrg_prep #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .func_i      (s_axis_tuser),
    .value_i     (s_axis_tdata[13:0]),
    .row_i       (s_axis_tdata[14]),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job),
    .digits_o    (digits)
  );

  coord_t rect_y, rect_x, rect_w, rect_h;

  ssrg_gen #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .digits_i    (digits),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .rect_y_o    (rect_y),
    .rect_x_o    (rect_x),
    .rect_w_o    (rect_w),
    .rect_h_o    (rect_h),
    .erase_o     (m_axis_tuser),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {rect_h, rect_w, rect_x, rect_y};

endmodule

`default_nettype wire
